// ----- sv/periodic_task_tick_scheduler_defines.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define PTTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define PTTS_ASSERT_NOW(lbl, ante, cons)
`define PTTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/ptts_pkg.sv -----
// Types, codes and constants of the periodic task tick scheduler.
package ptts_pkg;

  localparam int SlotsDef   = 8;
  localparam int MaxResults = 8;
  localparam int NCntW      = $clog2(MaxResults + 1);

  localparam logic [2:0] ActTick    = 3'd0;
  localparam logic [2:0] ActAdd     = 3'd1;
  localparam logic [2:0] ActRemove  = 3'd2;
  localparam logic [2:0] ActRerun   = 3'd3;
  localparam logic [2:0] ActArrange = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_id;
    logic [2:0] fired_slot;
    logic       status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [15:0] count;
    logic [7:0]  rank;
  } slot_rec_t;

  typedef enum logic [1:0] {
    UnitDec = 2'd0,
    UnitGt  = 2'd1,
    UnitEq  = 2'd2
  } unit_mode_t;

  typedef struct packed {
    logic [15:0] value;
    logic        flag;
  } unit_res_t;

endpackage

// ----- sv/periodic_task_tick_scheduler.sv -----
// Add writes one slot; remove, rerun and tick walk every slot, ticks also
// held by output stalls; arrange exchange-sorts, one slot compare per cycle.
// Throughput: one transaction at a time; the sequencer walks the slot table
// through a single read index and a single shared decrement/compare unit.
// Results leave at most one per cycle via a one-deep, stallable output register.
// Reset (rst_n low, synchronous): table reads as empty, all slots disabled.
module periodic_task_tick_scheduler #(
  parameter int SLOTS = ptts_pkg::SlotsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ptts_pkg::out_item_t out_data
);
  import ptts_pkg::*;

  `include "periodic_task_tick_scheduler_defines.svh"

  localparam int SlotW = $clog2(SLOTS);
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam logic [SlotW-1:0] LastIdx  = SlotW'(SLOTS - 1);
  localparam logic [SlotW-1:0] LastRow  = SlotW'(SLOTS - 2);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(SLOTS);
  localparam logic [NCntW-1:0] MaxRes   = NCntW'(MaxResults);

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ADD   = 10'b0000000010,
    S_TICK  = 10'b0000000100,
    S_FLUSH = 10'b0000001000,
    S_LOAD  = 10'b0000010000,
    S_SORT  = 10'b0000100000,
    S_PUT   = 10'b0001000000,
    S_ENA   = 10'b0010000000,
    S_MATCH = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t           st_r, st_nxt;
  in_item_t         cmd_r, cmd_nxt;
  logic [SlotW-1:0] idx_r, idx_nxt;       // inner walk index (j)
  logic [SlotW-1:0] row_r, row_nxt;       // outer sort index (i)
  slot_rec_t        held_r, held_nxt;     // slot i contents during a sort pass
  logic             status_r, status_nxt;
  logic [CntW-1:0]  added_r, added_nxt;
  logic [NCntW-1:0] n_r, n_nxt;           // firings reported this tick
  logic             pend_v_r, pend_v_nxt; // held-back firing, waits for "last"
  out_item_t        pend_r, pend_nxt;

  logic             out_valid_r;
  out_item_t        out_data_r;

  // Table ports.
  logic [SlotW-1:0] rd_idx;
  slot_rec_t        rd_rec;
  logic             rd_en;
  logic             wr_we;
  logic [SlotW-1:0] wr_idx;
  slot_rec_t        wr_rec;
  logic             en_clr;
  logic             en_we;
  logic [SlotW-1:0] en_idx;
  logic             en_val;

  // Shared unit.
  unit_mode_t       u_mode;
  logic [15:0]      u_a;
  logic [15:0]      u_b;
  unit_res_t        u_res;

  logic             in_acc;
  logic             out_free;
  logic             emit;
  out_item_t        emit_data;
  logic             fire;
  logic             report;

  ptts_table #(.SLOTS(SLOTS)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd_rec (rd_rec),
    .rd_en  (rd_en),
    .wr_we  (wr_we),
    .wr_idx (wr_idx),
    .wr_rec (wr_rec),
    .en_clr (en_clr),
    .en_we  (en_we),
    .en_idx (en_idx),
    .en_val (en_val)
  );

  ptts_unit u_unit (
    .mode (u_mode),
    .op_a (u_a),
    .op_b (u_b),
    .res  (u_res)
  );

  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Read the outer slot while loading a pass, the walk slot otherwise.
  assign rd_idx = (st_r == S_LOAD) ? row_r : idx_r;

  // Operand select for the shared unit.
  always_comb begin
    u_mode = UnitDec;
    u_a    = 16'd0;
    u_b    = 16'd0;
    unique case (st_r)
      S_TICK: begin
        u_mode = UnitDec;
        u_a    = rd_rec.count;
      end
      S_SORT: begin
        u_mode = UnitGt;
        u_a    = {8'd0, held_r.rank};
        u_b    = {8'd0, rd_rec.rank};
      end
      S_MATCH: begin
        u_mode = UnitEq;
        u_a    = {8'd0, rd_rec.task_id};
        u_b    = {8'd0, cmd_r.task_id};
      end
      default: begin
        u_mode = UnitDec;
        u_a    = 16'd0;
        u_b    = 16'd0;
      end
    endcase
  end

  assign fire   = rd_en && u_res.flag;
  assign report = fire && (n_r < MaxRes);

  // Sequencer.
  always_comb begin
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    held_nxt   = held_r;
    status_nxt = status_r;
    added_nxt  = added_r;
    n_nxt      = n_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    wr_we      = 1'b0;
    wr_idx     = idx_r;
    wr_rec     = rd_rec;
    en_clr     = 1'b0;
    en_we      = 1'b0;
    en_idx     = idx_r;
    en_val     = 1'b0;
    emit       = 1'b0;
    emit_data  = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_data;
          idx_nxt    = '0;
          row_nxt    = '0;
          status_nxt = 1'b0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          unique case (in_data.action)
            ActTick:    st_nxt = S_TICK;
            ActAdd:     st_nxt = S_ADD;
            ActRemove:  st_nxt = S_MATCH;
            ActRerun:   st_nxt = S_MATCH;
            ActArrange: begin
              // Enables are rebuilt after the sort; drop them now so they
              // never sit beside a moved record.
              en_clr = 1'b1;
              st_nxt = S_LOAD;
            end
            default:    st_nxt = S_DONE;
          endcase
        end
      end

      S_ADD: begin
        if (added_r == FullCnt) begin
          status_nxt = 1'b1;
        end else begin
          wr_we          = 1'b1;
          wr_idx         = added_r[SlotW-1:0];
          wr_rec.task_id = cmd_r.task_id;
          wr_rec.period  = cmd_r.period;
          wr_rec.count   = cmd_r.period;
          wr_rec.rank    = cmd_r.priority_req;
          en_we          = 1'b1;
          en_idx         = added_r[SlotW-1:0];
          en_val         = (cmd_r.task_id != 8'd0);
          added_nxt      = added_r + 1'b1;
        end
        st_nxt = S_DONE;
      end

      S_TICK: begin
        // Hold the walk when a new firing must push out the pending one
        // and the output register is still full.
        if (!(report && pend_v_r && !out_free)) begin
          if (rd_en) begin
            wr_we        = 1'b1;
            wr_rec.count = fire ? rd_rec.period : u_res.value;
          end
          if (report) begin
            if (pend_v_r) begin
              emit      = 1'b1;
              emit_data = pend_r;
            end
            pend_v_nxt          = 1'b1;
            pend_nxt.fired      = 1'b1;
            pend_nxt.fired_id   = rd_rec.task_id;
            pend_nxt.fired_slot = 3'(idx_r);
            pend_nxt.status     = 1'b0;
            pend_nxt.last       = 1'b0;
            n_nxt               = n_r + 1'b1;
          end
          if (idx_r == LastIdx) begin
            st_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_v_r) begin
            emit_data      = pend_r;
            emit_data.last = 1'b1;
          end else begin
            emit_data.last = 1'b1;
          end
          pend_v_nxt = 1'b0;
          st_nxt     = S_IDLE;
        end
      end

      S_LOAD: begin
        held_nxt = rd_rec;
        idx_nxt  = row_r + 1'b1;
        st_nxt   = S_SORT;
      end

      S_SORT: begin
        // Exchange: the smaller rank stays held for slot i.
        if (u_res.flag) begin
          wr_we    = 1'b1;
          wr_idx   = idx_r;
          wr_rec   = held_r;
          held_nxt = rd_rec;
        end
        if (idx_r == LastIdx) begin
          st_nxt = S_PUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_PUT: begin
        wr_we  = 1'b1;
        wr_idx = row_r;
        wr_rec = held_r;
        if (row_r == LastRow) begin
          idx_nxt = '0;
          st_nxt  = S_ENA;
        end else begin
          row_nxt = row_r + 1'b1;
          st_nxt  = S_LOAD;
        end
      end

      S_ENA: begin
        en_we  = 1'b1;
        en_val = (rd_rec.task_id != 8'd0);
        if (idx_r == LastIdx) begin
          st_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_MATCH: begin
        if (u_res.flag) begin
          en_we  = 1'b1;
          en_val = (cmd_r.action == ActRerun) && (cmd_r.task_id != 8'd0);
        end
        if (idx_r == LastIdx) begin
          st_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_data.status = status_r;
          emit_data.last   = 1'b1;
          st_nxt           = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      added_r  <= '0;
      n_r      <= '0;
      pend_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      added_r  <= added_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    row_r    <= row_nxt;
    held_r   <= held_nxt;
    status_r <= status_nxt;
    pend_r   <= pend_nxt;
  end

  // Output register: load on emit, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An enabled slot never holds task id zero.
  `PTTS_ASSERT_NOW(a_en_id, rd_en, rd_rec.task_id != 8'd0)
  // The fill count never passes the table size.
  `PTTS_ASSERT_NOW(a_added_bound, 1'b1, added_r <= FullCnt)
  // A tick never reports more firings than the result limit.
  `PTTS_ASSERT_NOW(a_n_bound, 1'b1, n_r <= MaxRes)
  // An accepted transaction makes the block busy in the next cycle.
  `PTTS_ASSERT_NEXT(a_accept_busy, in_acc, in_stall)

endmodule

// ----- sv/ptts_unit.sv -----
// Shared decrement / compare unit used by the tick, sort and match steps.
module ptts_unit (
  input  ptts_pkg::unit_mode_t mode,
  input  logic [15:0]          op_a,
  input  logic [15:0]          op_b,
  output ptts_pkg::unit_res_t  res
);
  import ptts_pkg::*;

  logic [15:0] dec;

  assign dec = op_a - 16'd1;

  always_comb begin
    res.value = op_a;
    res.flag  = 1'b0;
    unique case (mode)
      UnitDec: begin
        res.value = dec;
        res.flag  = (dec == 16'd0);
      end
      UnitGt: res.flag = (op_a > op_b);
      UnitEq: res.flag = (op_a == op_b);
      default: begin
        res.value = op_a;
        res.flag  = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/ptts_table.sv -----
// Task slot table: one read index, one record write, enable bits with clear.
module ptts_table #(
  parameter int SLOTS = ptts_pkg::SlotsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [$clog2(SLOTS)-1:0]  rd_idx,
  output ptts_pkg::slot_rec_t       rd_rec,
  output logic                      rd_en,
  input  logic                      wr_we,
  input  logic [$clog2(SLOTS)-1:0]  wr_idx,
  input  ptts_pkg::slot_rec_t       wr_rec,
  input  logic                      en_clr,
  input  logic                      en_we,
  input  logic [$clog2(SLOTS)-1:0]  en_idx,
  input  logic                      en_val
);
  import ptts_pkg::*;

  slot_rec_t          rec_r [SLOTS];
  logic [SLOTS-1:0]   vld_r;
  logic [SLOTS-1:0]   en_r;

  // An entry never written reads as all zero.
  assign rd_rec = vld_r[rd_idx] ? rec_r[rd_idx] : '0;
  assign rd_en  = en_r[rd_idx];

  always_ff @(posedge clk) begin
    if (wr_we) begin
      rec_r[wr_idx] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      en_r  <= '0;
    end else begin
      if (wr_we) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (en_clr) begin
        en_r <= '0;
      end else if (en_we) begin
        en_r[en_idx] <= en_val;
      end
    end
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the periodic task tick scheduler: directed and random traffic.
module tb;
  import ptts_pkg::*;

  localparam int Slots        = SlotsDef;
  localparam int RandomItems  = 80;    // random transactions sent with idling on
  localparam int TailItems    = 25;    // random transactions sent back to back at the end
  localparam int QuietLimit   = 4000;  // cycles without any handshake before giving up
  localparam int DrainWait    = 80;    // covers the longest arrange pass after the last result
  localparam int PrintLimit   = 100;
  localparam logic [2:0] ActTopCode = 3'd7;  // highest action code; codes above arrange are unused

  // One entry of the scoreboard's copy of the task table.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [15:0] countdown;
    logic [7:0]  rank;
    logic        on;
  } task_entry_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Scoreboard copy of the scheduler state.
  task_entry_t sched_slots[Slots];
  int          sched_added = 0;

  in_item_t    pending_items[$];     // transactions waiting for the driver
  out_item_t   expected_results[$];  // firing reports and replies not yet seen
  logic [7:0]  known_ids[$];         // ids that were offered to add
  int          mismatches = 0;
  bit          idling = 1'b1;
  int          send_gap = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  periodic_task_tick_scheduler #(
    .SLOTS(Slots)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one accepted transaction to the scoreboard table and queue the
  // results it must produce: one per firing slot in slot order, or a single
  // reply carrying the add status.
  function automatic void predict_schedule(input in_item_t t);
    int          fired_at[$];
    out_item_t   r;
    task_entry_t swap;
    logic        rejected;
    rejected = 1'b0;
    case (t.action)
      ActTick: begin
        // Count down enabled slots; a slot reaching zero fires and reloads.
        // A countdown of zero wraps, so period zero fires every 65536 ticks.
        for (int i = 0; i < Slots; i++) begin
          if (sched_slots[i].on) begin
            sched_slots[i].countdown = sched_slots[i].countdown - 16'd1;
            if (sched_slots[i].countdown == 16'd0) begin
              sched_slots[i].countdown = sched_slots[i].period;
              if (fired_at.size() < MaxResults) fired_at.push_back(i);
            end
          end
        end
      end
      ActAdd: begin
        // Fill the slot at the add count; once every slot was added, reject.
        if (sched_added >= Slots) begin
          rejected = 1'b1;
        end else begin
          sched_slots[sched_added].id        = t.task_id;
          sched_slots[sched_added].period    = t.period;
          sched_slots[sched_added].countdown = t.period;
          sched_slots[sched_added].rank      = t.priority_req;
          sched_slots[sched_added].on        = (t.task_id != 8'd0);
          sched_added++;
        end
      end
      ActRemove: begin
        for (int i = 0; i < Slots; i++)
          if (sched_slots[i].id == t.task_id) sched_slots[i].on = 1'b0;
      end
      ActRerun: begin
        // Id zero never comes back to life.
        for (int i = 0; i < Slots; i++)
          if (sched_slots[i].id == t.task_id) sched_slots[i].on = (t.task_id != 8'd0);
      end
      ActArrange: begin
        // Exchange sort over the whole table, empty slots included, then
        // re-enable every slot that holds a task. The add count is kept.
        for (int i = 0; i + 1 < Slots; i++) begin
          for (int j = i; j < Slots; j++) begin
            if (sched_slots[i].rank > sched_slots[j].rank) begin
              swap           = sched_slots[i];
              sched_slots[i] = sched_slots[j];
              sched_slots[j] = swap;
            end
          end
        end
        for (int i = 0; i < Slots; i++) sched_slots[i].on = (sched_slots[i].id != 8'd0);
      end
      default: ;  // unused codes change nothing
    endcase

    r = '0;
    if (fired_at.size() == 0) begin
      r.status = rejected;
      r.last   = 1'b1;
      expected_results.push_back(r);
    end else begin
      foreach (fired_at[k]) begin
        r.fired      = 1'b1;
        r.fired_id   = sched_slots[fired_at[k]].id;
        r.fired_slot = 3'(fired_at[k]);
        r.status     = 1'b0;
        r.last       = (k == fired_at.size() - 1);
        expected_results.push_back(r);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PrintLimit)
      $display("mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // Compare one accepted result against the oldest expectation, field by field.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected, fired_id", got.fired_id, 0);
    end else begin
      want = expected_results.pop_front();
      if (got.fired != want.fired) report_mismatch("fired", got.fired, want.fired);
      if (got.fired_id != want.fired_id) report_mismatch("fired_id", got.fired_id, want.fired_id);
      if (got.fired_slot != want.fired_slot)
        report_mismatch("fired_slot", got.fired_slot, want.fired_slot);
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.last != want.last) report_mismatch("last", got.last, want.last);
    end
  endtask

  task automatic queue_item(input logic [2:0] act, input logic [7:0] id,
                            input logic [15:0] period, input logic [7:0] rank);
    in_item_t t;
    t.action       = act;
    t.task_id      = id;
    t.period       = period;
    t.priority_req = rank;
    if (act == ActAdd) known_ids.push_back(id);
    pending_items.push_back(t);
  endtask

  // Random transaction: mostly ticks so slots keep firing; remove and rerun
  // usually name an id that was offered to add. All fields carry random bits.
  function automatic in_item_t random_item();
    in_item_t t;
    int       pick;
    t.task_id      = 8'($urandom_range(0, 255));
    t.period       = 16'($urandom_range(0, 65535));
    t.priority_req = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 55)      t.action = ActTick;
    else if (pick < 67) t.action = ActRemove;
    else if (pick < 79) t.action = ActRerun;
    else if (pick < 86) t.action = ActArrange;
    else if (pick < 94) t.action = ActAdd;
    else                t.action = 3'($urandom_range(ActArrange + 1, ActTopCode));
    if ((t.action == ActRemove || t.action == ActRerun) && $urandom_range(0, 9) < 7)
      t.task_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
    return t;
  endfunction

  // Hold until the driver is empty and every expected result has come back.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Driver: predict on acceptance, then advance to the next transaction or
  // insert an idle burst. A stalled transaction holds its payload.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_schedule(in_data);
        if (idling && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted results and stall the output in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no handshake happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (sched_slots[i]) sched_slots[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Start with a tick on the empty table: no firing.
    queue_item(ActTick, 8'd0, 16'd0, 8'd0);
    // Fill half the table: highest id, id zero (never enabled), lowest rank,
    // and period zero (countdown wraps to 65535).
    queue_item(ActAdd, 8'd255, 16'd1, 8'd200);
    queue_item(ActAdd, 8'd0, 16'd2, 8'd255);
    queue_item(ActAdd, 8'd1, 16'd3, 8'd0);
    queue_item(ActAdd, 8'd2, 16'd0, 8'd10);
    repeat (3) queue_item(ActTick, 8'd0, 16'd0, 8'd0);
    // Drop a task, tick without it, bring it back; rerun of id zero does nothing.
    queue_item(ActRemove, 8'd255, 16'd0, 8'd0);
    queue_item(ActTick, 8'd0, 16'd0, 8'd0);
    queue_item(ActRerun, 8'd255, 16'd0, 8'd0);
    queue_item(ActRerun, 8'd0, 16'd0, 8'd0);
    queue_item(ActRemove, 8'd77, 16'd0, 8'd0);
    // Arrange with empty slots: their rank zero pulls them to the front, so
    // the next add overwrites whatever now sits at the add count.
    queue_item(ActArrange, 8'd0, 16'd0, 8'd0);
    queue_item(ActTick, 8'd0, 16'd0, 8'd0);
    queue_item(ActAdd, 8'd3, 16'd2, 8'd128);
    queue_item(ActAdd, 8'd4, 16'hFFFF, 8'd1);
    queue_item(ActAdd, 8'd5, 16'd1, 8'd3);
    queue_item(ActAdd, 8'd6, 16'd2, 8'd7);
    // Table full: this add must be rejected.
    queue_item(ActAdd, 8'd7, 16'd5, 8'd50);
    queue_item(ActTick, 8'd0, 16'd0, 8'd0);
    queue_item(ActArrange, 8'd0, 16'd0, 8'd0);
    queue_item(ActTick, 8'd0, 16'd0, 8'd0);
    // Unused action codes reply with a plain done.
    for (int c = ActArrange + 1; c <= ActTopCode; c++)
      queue_item(3'(c), 8'($urandom_range(0, 255)), 16'd0, 8'd0);

    // Hold the sender until every expected result is back.
    wait_for_drain();

    // Random part with idle bursts on both sides.
    for (int n = 0; n < RandomItems; n++) pending_items.push_back(random_item());
    do @(negedge clk);
    while (pending_items.size() != 0);

    // Last stretch runs at full rate on both sides.
    idling = 1'b0;
    for (int n = 0; n < TailItems; n++) pending_items.push_back(random_item());
    wait_for_drain();
    repeat (DrainWait) @(posedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ptts_pkg.sv
sv/ptts_unit.sv
sv/ptts_table.sv
sv/periodic_task_tick_scheduler.sv
sim/tb.sv
